// File: src/radix_integer_to_ascii_unit_macros.svh
// Assertion macros used by the top-level RTL file.
`ifndef RADIX_INTEGER_TO_ASCII_UNIT_MACROS_SVH
`define RADIX_INTEGER_TO_ASCII_UNIT_MACROS_SVH

`ifndef SYNTHESIS
`define RITOA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define RITOA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define RITOA_ASSERT_IMP(lbl, ante, cons, msg)
`define RITOA_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

// File: src/ritoa_pkg.sv
package ritoa_pkg;

  localparam int VALUE_WIDTH = 32;
  localparam int VALUE_BITS  = 32;
  localparam int RADIX_W     = 6;
  localparam int CHAR_W      = 7;
  localparam int WORK_W      = (VALUE_WIDTH < VALUE_BITS) ? VALUE_WIDTH : VALUE_BITS;
  localparam int ADDR_W      = $clog2(WORK_W);
  localparam int BIT_W       = $clog2(WORK_W);
  localparam int CNT_W       = $clog2(WORK_W + 1);

  localparam logic [RADIX_W-1:0] MIN_RADIX = RADIX_W'(2);
  localparam logic [RADIX_W-1:0] MAX_RADIX = RADIX_W'(36);
  localparam logic [RADIX_W-1:0] DEC_DIGITS = RADIX_W'(10);
  localparam logic [CHAR_W-1:0]  CHAR_ZERO  = CHAR_W'(48);
  localparam logic [CHAR_W-1:0]  CHAR_UPPER_A = CHAR_W'(65);
  localparam logic [CHAR_W-1:0]  CHAR_NONE  = '0;

  typedef logic [3:0] step_t;

  localparam step_t S_IDLE  = 4'd0;
  localparam step_t S_CHECK = 4'd1;
  localparam step_t S_DINIT = 4'd2;
  localparam step_t S_DSTEP = 4'd3;
  localparam step_t S_PUSH  = 4'd4;
  localparam step_t S_RD    = 4'd5;
  localparam step_t S_EMIT  = 4'd6;
  localparam step_t S_NEXT  = 4'd7;
  localparam step_t S_DONE  = 4'd8;
  localparam step_t S_BAD   = 4'd9;
  localparam step_t S_BDONE = 4'd10;

  typedef enum logic [2:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_IN,
    C_BAD,
    C_BITS,
    C_QNZ,
    C_OBUSY,
    C_CNZ
  } cond_t;

  typedef struct packed {
    logic  in_rdy;
    logic  load;
    logic  div_init;
    logic  div_step;
    logic  push;
    logic  rd;
    logic  emit_dig;
    logic  emit_bad;
    cond_t cond;
    step_t target;
  } ctrl_t;

  typedef struct packed {
    logic in_valid;
    logic bad;
    logic bits_nz;
    logic q_nz;
    logic out_busy;
    logic cnt_nz;
  } seq_stat_t;

  function automatic ctrl_t ucode(input step_t s);
    ctrl_t c;
    c = '0;
    c.cond = C_NEVER;
    c.target = S_IDLE;
    case (s)
      S_IDLE: begin
        c.in_rdy = 1'b1;
        c.load = 1'b1;
        c.cond = C_NO_IN;
        c.target = S_IDLE;
      end
      S_CHECK: begin
        c.cond = C_BAD;
        c.target = S_BAD;
      end
      S_DINIT: begin
        c.div_init = 1'b1;
      end
      S_DSTEP: begin
        c.div_step = 1'b1;
        c.cond = C_BITS;
        c.target = S_DSTEP;
      end
      S_PUSH: begin
        c.push = 1'b1;
        c.cond = C_QNZ;
        c.target = S_DINIT;
      end
      S_RD: begin
        c.rd = 1'b1;
      end
      S_EMIT: begin
        c.emit_dig = 1'b1;
        c.cond = C_OBUSY;
        c.target = S_EMIT;
      end
      S_NEXT: begin
        c.cond = C_CNZ;
        c.target = S_RD;
      end
      S_DONE: begin
        c.cond = C_ALWAYS;
        c.target = S_IDLE;
      end
      S_BAD: begin
        c.emit_bad = 1'b1;
        c.cond = C_OBUSY;
        c.target = S_BAD;
      end
      S_BDONE: begin
        c.cond = C_ALWAYS;
        c.target = S_IDLE;
      end
      default: begin
        c.cond = C_ALWAYS;
        c.target = S_IDLE;
      end
    endcase
    return c;
  endfunction

  function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [RADIX_W-1:0] d);
    logic [CHAR_W-1:0] r;
    if (d < DEC_DIGITS) begin
      r = CHAR_ZERO + CHAR_W'(d);
    end else begin
      r = CHAR_UPPER_A + CHAR_W'(d - DEC_DIGITS);
    end
    return r;
  endfunction

endpackage

// File: src/ritoa_if.sv
interface ritoa_in_if;
  import ritoa_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [VALUE_BITS-1:0] value;
  logic [RADIX_W-1:0]    radix;

  modport source (output valid, value, radix, input ready);
  modport sink (input valid, value, radix, output ready);
endinterface

interface ritoa_out_if;
  import ritoa_pkg::*;

  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] digit_char;
  logic              last;
  logic              bad_radix;

  modport source (output valid, digit_char, last, bad_radix, input ready);
  modport sink (input valid, digit_char, last, bad_radix, output ready);
endinterface

// File: src/radix_integer_to_ascii_unit.sv
// After the radix check a restoring divider finds one quotient bit per cycle
// and pushes each remainder digit onto the stack until the quotient is zero;
// digits are then popped and emitted most significant first. A bad radix gives
// one flagged character. No new input is taken until the last one is emitted.
// Reset: synchronous, active low; returns the sequencer to idle and empties the
// output register. The digit stack needs no clearing.
`include "radix_integer_to_ascii_unit_macros.svh"

module radix_integer_to_ascii_unit (
  input  logic        clk,
  input  logic        rst_n,
  ritoa_in_if.sink    in_if,
  ritoa_out_if.source out_if
);
  import ritoa_pkg::*;

  ctrl_t     ctrl;
  seq_stat_t stat;

  logic [WORK_W-1:0]  q_r;
  logic [WORK_W-1:0]  q_nxt;
  logic [RADIX_W-1:0] rem_r;
  logic [RADIX_W-1:0] rem_nxt;
  logic [RADIX_W-1:0] base_r;
  logic [RADIX_W-1:0] base_nxt;
  logic [BIT_W-1:0]   bitcnt_r;
  logic [BIT_W-1:0]   bitcnt_nxt;
  logic [CNT_W-1:0]   cnt_r;
  logic [CNT_W-1:0]   cnt_nxt;
  logic [CNT_W-1:0]   cnt_dec;
  logic [RADIX_W:0]   partial;
  logic [RADIX_W-1:0] rd_digit;

  logic              out_valid_r;
  logic              out_valid_nxt;
  logic [CHAR_W-1:0] out_char_r;
  logic [CHAR_W-1:0] out_char_nxt;
  logic              out_last_r;
  logic              out_last_nxt;
  logic              out_bad_r;
  logic              out_bad_nxt;
  logic              out_busy;

  ritoa_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .ctrl  (ctrl)
  );

  ritoa_ram #(
    .WIDTH (RADIX_W),
    .DEPTH (WORK_W)
  ) u_stack (
    .clk   (clk),
    .we    (ctrl.push),
    .waddr (cnt_r[ADDR_W-1:0]),
    .wdata (rem_r),
    .re    (ctrl.rd),
    .raddr (cnt_dec[ADDR_W-1:0]),
    .rdata (rd_digit)
  );

  assign out_busy = out_valid_r && !out_if.ready;
  assign cnt_dec  = cnt_r - CNT_W'(1);
  assign partial  = {rem_r, q_r[WORK_W-1]};

  assign stat.in_valid = in_if.valid;
  assign stat.bad      = (base_r < MIN_RADIX) || (base_r > MAX_RADIX);
  assign stat.bits_nz  = (bitcnt_r != '0);
  assign stat.q_nz     = (q_r != '0);
  assign stat.out_busy = out_busy;
  assign stat.cnt_nz   = (cnt_r != '0);

  always_comb begin
    q_nxt      = q_r;
    rem_nxt    = rem_r;
    base_nxt   = base_r;
    bitcnt_nxt = bitcnt_r;
    cnt_nxt    = cnt_r;
    if (ctrl.load && in_if.valid) begin
      q_nxt    = in_if.value[WORK_W-1:0];
      base_nxt = in_if.radix;
      cnt_nxt  = '0;
    end
    if (ctrl.div_init) begin
      rem_nxt    = '0;
      bitcnt_nxt = BIT_W'(WORK_W - 1);
    end
    if (ctrl.div_step) begin
      bitcnt_nxt = bitcnt_r - BIT_W'(1);
      if (partial >= {1'b0, base_r}) begin
        rem_nxt = RADIX_W'(partial - {1'b0, base_r});
        q_nxt   = {q_r[WORK_W-2:0], 1'b1};
      end else begin
        rem_nxt = partial[RADIX_W-1:0];
        q_nxt   = {q_r[WORK_W-2:0], 1'b0};
      end
    end
    if (ctrl.push) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end
    if (ctrl.rd) begin
      cnt_nxt = cnt_dec;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r && !out_if.ready;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    out_bad_nxt   = out_bad_r;
    if (ctrl.emit_dig && !out_busy) begin
      out_valid_nxt = 1'b1;
      out_char_nxt  = digit_to_ascii(rd_digit);
      out_last_nxt  = (cnt_r == '0);
      out_bad_nxt   = 1'b0;
    end
    if (ctrl.emit_bad && !out_busy) begin
      out_valid_nxt = 1'b1;
      out_char_nxt  = CHAR_NONE;
      out_last_nxt  = 1'b1;
      out_bad_nxt   = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      bitcnt_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      bitcnt_r    <= bitcnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r        <= q_nxt;
    rem_r      <= rem_nxt;
    base_r     <= base_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
    out_bad_r  <= out_bad_nxt;
  end

  assign in_if.ready       = ctrl.in_rdy && rst_n;
  assign out_if.valid      = out_valid_r;
  assign out_if.digit_char = out_char_r;
  assign out_if.last       = out_last_r;
  assign out_if.bad_radix  = out_bad_r;

  `RITOA_ASSERT_NXT(a_busy_after_take, in_if.valid && in_if.ready, !in_if.ready, "accepted transaction did not close input")
  `RITOA_ASSERT_IMP(a_cnt_bound, 1'b1, cnt_r <= CNT_W'(WORK_W), "digit count exceeds stack depth")
  `RITOA_ASSERT_IMP(a_rem_below_base, ctrl.push, rem_r < base_r, "remainder not reduced below radix")
  `RITOA_ASSERT_IMP(a_pop_nonempty, ctrl.rd, cnt_r != '0, "read from empty digit stack")

endmodule

// File: src/ritoa_ram.sv
module ritoa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: src/ritoa_seq.sv
module ritoa_seq (
  input  logic                 clk,
  input  logic                 rst_n,
  input  ritoa_pkg::seq_stat_t stat,
  output ritoa_pkg::ctrl_t     ctrl
);
  import ritoa_pkg::*;

  step_t pc_r;
  step_t pc_nxt;
  ctrl_t word;
  logic  take;

  always_comb begin
    word = ucode(pc_r);
    case (word.cond)
      C_NEVER:  take = 1'b0;
      C_ALWAYS: take = 1'b1;
      C_NO_IN:  take = !stat.in_valid;
      C_BAD:    take = stat.bad;
      C_BITS:   take = stat.bits_nz;
      C_QNZ:    take = stat.q_nz;
      C_OBUSY:  take = stat.out_busy;
      C_CNZ:    take = stat.cnt_nz;
      default:  take = 1'b0;
    endcase
    pc_nxt = take ? word.target : pc_r + step_t'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= S_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

  assign ctrl = word;

endmodule

// File: tb/radix_integer_to_ascii_unit_tb.sv
`timescale 1ns / 100ps

module radix_integer_to_ascii_unit_tb;
  import ritoa_pkg::*;

  typedef struct {
    logic [VALUE_BITS-1:0] value;
    logic [RADIX_W-1:0]    radix;
  } conv_req_t;

  typedef struct {
    logic [CHAR_W-1:0] ch;
    logic              last;
    logic              bad;
  } digit_t;

  localparam int RANDOM_ITEMS = 200;
  localparam int LONG_HOLD    = 2500;

  logic clk;
  logic rst_n;

  ritoa_in_if  in_ch ();
  ritoa_out_if out_ch ();

  radix_integer_to_ascii_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch.sink),
    .out_if (out_ch.source)
  );

  conv_req_t numbers_to_send [$];
  digit_t    expected_digits [$];

  int   error_count    = 0;
  int   send_gap       = 0;
  int   stall_left     = 0;
  int   hold_left      = 0;
  logic long_hold_done = 1'b0;
  logic random_phase   = 1'b0;
  logic quiet_tail     = 1'b0;

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.value = '0;
    in_ch.radix = '0;
    out_ch.ready = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #40_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    $display("ERROR @%0t: %s", $time, msg);
    error_count++;
  endtask

  function automatic void predict_digits(input logic [VALUE_BITS-1:0] v,
                                         input logic [RADIX_W-1:0] r);
    logic [WORK_W-1:0] n;
    logic [CHAR_W-1:0] rev [$];
    int unsigned       d;
    digit_t            e;
    n = v[WORK_W-1:0];
    if (r < MIN_RADIX || r > MAX_RADIX) begin
      e.ch = CHAR_NONE;
      e.last = 1'b1;
      e.bad = 1'b1;
      expected_digits.push_back(e);
      return;
    end
    if (n == '0) begin
      rev.push_back(CHAR_ZERO);
    end
    while (n != '0) begin
      d = n % r;
      if (d < DEC_DIGITS) begin
        rev.push_back(CHAR_ZERO + CHAR_W'(d));
      end else begin
        rev.push_back(CHAR_UPPER_A + CHAR_W'(d - DEC_DIGITS));
      end
      n = n / r;
    end
    for (int k = rev.size() - 1; k >= 0; k--) begin
      e.ch = rev[k];
      e.last = (k == 0);
      e.bad = 1'b0;
      expected_digits.push_back(e);
    end
  endfunction

  task automatic check_digit();
    digit_t e;
    if (expected_digits.size() == 0) begin
      report_mismatch($sformatf("unexpected digit char=%h last=%b bad=%b",
                                out_ch.digit_char, out_ch.last, out_ch.bad_radix));
      return;
    end
    e = expected_digits.pop_front();
    if (out_ch.digit_char !== e.ch) begin
      report_mismatch($sformatf("digit_char %h, want %h", out_ch.digit_char, e.ch));
    end
    if (out_ch.last !== e.last) begin
      report_mismatch($sformatf("last %b, want %b", out_ch.last, e.last));
    end
    if (out_ch.bad_radix !== e.bad) begin
      report_mismatch($sformatf("bad_radix %b, want %b", out_ch.bad_radix, e.bad));
    end
  endtask

  task automatic queue_number(input logic [VALUE_BITS-1:0] v, input int r);
    numbers_to_send.push_back('{value: v, radix: RADIX_W'(r)});
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_ch.value <= '0;
      in_ch.radix <= '0;
      send_gap <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        predict_digits(in_ch.value, in_ch.radix);
      end
      if (in_ch.valid && !in_ch.ready) begin
        // hold the offered transaction
      end else if (send_gap > 0) begin
        in_ch.valid <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (numbers_to_send.size() == 0) begin
        in_ch.valid <= 1'b0;
      end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
        in_ch.valid <= 1'b0;
        send_gap <= $urandom_range(0, 8);
      end else begin
        in_ch.valid <= 1'b1;
        in_ch.value <= numbers_to_send[0].value;
        in_ch.radix <= numbers_to_send[0].radix;
        numbers_to_send.pop_front();
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      stall_left <= 0;
      hold_left <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        check_digit();
      end
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_left <= hold_left - 1;
      end else if (!long_hold_done && random_phase
                   && numbers_to_send.size() < RANDOM_ITEMS - 50) begin
        // back up the converter while the sender keeps offering
        long_hold_done <= 1'b1;
        hold_left <= LONG_HOLD - 1;
        out_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left <= stall_left - 1;
      end else if (!quiet_tail && $urandom_range(0, 4) == 0) begin
        out_ch.ready <= 1'b0;
        stall_left <= $urandom_range(0, 8);
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  initial begin
    logic [VALUE_BITS-1:0] v;
    int                    r;

    queue_number(32'd0, 10);
    queue_number(32'd0, 0);
    queue_number(32'hFFFF_FFFF, 2);
    queue_number(32'h8000_0000, 2);
    queue_number(32'd1, 2);
    queue_number(32'hFFFF_FFFF, 36);
    queue_number(32'd35, 36);
    queue_number(32'd36, 36);
    queue_number(32'd10, 11);
    queue_number(32'd9, 10);
    queue_number(32'hFFFF_FFFF, 16);
    queue_number(32'h1234_5678, 8);
    queue_number(32'd255, 16);
    queue_number(32'd123456789, 10);
    queue_number(32'd5, 1);
    queue_number(32'hFFFF_FFFF, 37);
    queue_number(32'd7, 63);
    queue_number(32'd0, 36);
    queue_number(32'h5555_5555, 3);
    queue_number(32'hAAAA_AAAA, 35);
    queue_number(32'd100, 0);
    queue_number(32'd0, 2);

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // drain everything before the random part
    @(negedge clk);
    while (numbers_to_send.size() != 0 || in_ch.valid || expected_digits.size() != 0) begin
      @(negedge clk);
    end

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if ($urandom_range(0, 9) == 0) begin
        r = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 1) : $urandom_range(37, 63);
      end else begin
        r = $urandom_range(2, 36);
      end
      case ($urandom_range(0, 4))
        0: v = $urandom();
        1: v = $urandom_range(0, 1000);
        2: v = $urandom() >> $urandom_range(0, 31);
        3: v = ($urandom_range(0, 1) == 0) ? 32'hFFFF_FFFF : 32'd0;
        default: v = $urandom() | $urandom();
      endcase
      queue_number(v, r);
    end
    random_phase = 1'b1;

    while (numbers_to_send.size() >= 30) begin
      @(negedge clk);
    end
    quiet_tail = 1'b1;

    while (numbers_to_send.size() != 0 || in_ch.valid || expected_digits.size() != 0) begin
      @(negedge clk);
    end
    repeat (200) @(posedge clk);

    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
